// File: src/gsm_7bit_text_encoder_unit_defines.svh
// assertion macros shared by the checker
`ifndef GSM_7BIT_TEXT_ENCODER_UNIT_DEFINES_SVH
`define GSM_7BIT_TEXT_ENCODER_UNIT_DEFINES_SVH

// implication into the next cycle, quiet while reset is high
`define GSM7_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication into the next cycle, checked during reset as well
`define GSM7_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/gsm7_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gsm7_pkg;

   localparam int unsigned ALPHA_SIZE  = 128;
   localparam int unsigned QUEUE_DEPTH = 4;

   // gsm default alphabet, index is the septet code
   localparam logic [7:0] ALPHABET [ALPHA_SIZE] = '{
      8'd64,  8'd163, 8'd36,  8'd165, 8'd232, 8'd233, 8'd249, 8'd236, 8'd242, 8'd199,
      8'd10,  8'd216, 8'd248, 8'd13,  8'd197, 8'd229, 8'd16,  8'd95,  8'd18,  8'd19,
      8'd20,  8'd21,  8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd198, 8'd230,
      8'd223, 8'd201, 8'd32,  8'd33,  8'd34,  8'd35,  8'd164, 8'd37,  8'd38,  8'd39,
      8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
      8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
      8'd60,  8'd61,  8'd62,  8'd63,  8'd161, 8'd65,  8'd66,  8'd67,  8'd68,  8'd69,
      8'd70,  8'd71,  8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
      8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,  8'd89,
      8'd90,  8'd196, 8'd214, 8'd209, 8'd220, 8'd167, 8'd191, 8'd97,  8'd98,  8'd99,
      8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109,
      8'd110, 8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
      8'd120, 8'd121, 8'd122, 8'd228, 8'd246, 8'd241, 8'd252, 8'd224
   };

   // one octet of the packed stream
   typedef struct packed {
      logic [7:0] octet;
      logic       final_flag;
   } entry_type;

   // what the packer hands to the output queue in one transfer
   typedef struct packed {
      logic [1:0] push_count;
      entry_type  first;
      entry_type  second;
   } push_type;

   // byte to septet code, lowest matching index wins, no match gives 0
   // all operands are constants apart from the byte, so this folds into a rom
   function automatic logic [6:0] to_septet(input logic [7:0] text_byte);
      logic [6:0] code;
      code = 7'd0;
      for (int k = ALPHA_SIZE - 1; k >= 0; k--) begin
         if (text_byte == ALPHABET[k]) begin
            code = 7'(k);
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// File: src/gsm7_packer.sv
`timescale 1ns / 1ps
`default_nettype none

module gsm7_packer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_text_byte,
   input  wire logic              req_final_char,
   input  wire logic              queue_space,
   output gsm7_pkg::push_type     push
);

   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff;
   logic       hold_final_ff;
   logic [2:0] char_pos_ff, char_pos_in;
   logic [6:0] carry_ff, carry_in;

   logic        advance;
   logic        accept;
   logic [6:0]  code;
   logic [14:0] shifted;
   logic [7:0]  regular_octet;
   logic [6:0]  carry_next;
   logic        has_regular;
   logic        has_flush;
   gsm7_pkg::entry_type regular_entry;
   gsm7_pkg::entry_type flush_entry;

   // held item moves on whenever the queue has room for two octets
   assign advance   = hold_valid_ff && queue_space;
   assign req_stall = hold_valid_ff && !queue_space;
   assign accept    = req_valid && !req_stall;

   // code lookup and septet packing
   always_comb begin
      code          = gsm7_pkg::to_septet(hold_byte_ff);
      shifted       = {8'd0, code} << (4'd8 - {1'b0, char_pos_ff});
      regular_octet = shifted[7:0] | {1'b0, carry_ff};
      carry_next    = (char_pos_ff == 3'd0) ? code : (code >> char_pos_ff);
      has_regular   = (char_pos_ff != 3'd0);
      has_flush     = hold_final_ff && (char_pos_ff != 3'd7);

      regular_entry.octet      = regular_octet;
      regular_entry.final_flag = hold_final_ff && (char_pos_ff == 3'd7);
      flush_entry.octet        = {1'b0, carry_next};
      flush_entry.final_flag   = 1'b1;

      push.push_count = {1'b0, advance && has_regular} + {1'b0, advance && has_flush};
      if (has_regular) begin
         push.first  = regular_entry;
         push.second = flush_entry;
      end else begin
         push.first  = flush_entry;
         push.second = flush_entry;
      end
   end

   // next state
   always_comb begin
      hold_valid_in = hold_valid_ff;
      char_pos_in   = char_pos_ff;
      carry_in      = carry_ff;
      if (advance) begin
         hold_valid_in = 1'b0;
         if (hold_final_ff) begin
            char_pos_in = 3'd0;
            carry_in    = 7'd0;
         end else begin
            char_pos_in = char_pos_ff + 3'd1;
            carry_in    = carry_next;
         end
      end
      if (accept) begin
         hold_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         char_pos_ff   <= 3'd0;
         carry_ff      <= 7'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         char_pos_ff   <= char_pos_in;
         carry_ff      <= carry_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_byte_ff  <= req_text_byte;
         hold_final_ff <= req_final_char;
      end
   end

endmodule

`default_nettype wire

// File: src/gsm7_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gsm7_out_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire gsm7_pkg::push_type push,
   output logic                    queue_space,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_packed_octet,
   output logic                    rsp_final_octet
);

   localparam int unsigned PTR_W = $clog2(gsm7_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(gsm7_pkg::QUEUE_DEPTH + 1);

   gsm7_pkg::entry_type mem_ff [gsm7_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_ptr_next;

   assign queue_space = (count_ff <= CNT_W'(gsm7_pkg::QUEUE_DEPTH - 2));
   assign rsp_valid   = (count_ff != '0);
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   assign rsp_packed_octet = mem_ff[rd_ptr_ff].octet;
   assign rsp_final_octet  = mem_ff[rd_ptr_ff].final_flag;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // octet storage, up to two writes per cycle into free slots
   always_ff @(posedge clock) begin
      if (push.push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

// File: src/gsm_7bit_text_encoder_unit.sv
`timescale 1ns / 1ps
// path: a character's result passes the input register, then the octet queue, before it transfers
// throughput: one character per cycle unless req_stall; the last character of a message
//   may give two octets, which the 4-entry octet queue drains one per cycle unless rsp_stall
// reset: synchronous, active high; clears character position, carry bits and the octet queue
`default_nettype none

module gsm_7bit_text_encoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_final_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_packed_octet,
   output logic            rsp_final_octet
);

   gsm7_pkg::push_type push;
   logic               queue_space;

   // lookup and packing
   gsm7_packer u_packer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_final_char (req_final_char),
      .queue_space    (queue_space),
      .push           (push)
   );

   // octet queue toward the result channel
   gsm7_out_queue u_out_queue (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .queue_space      (queue_space),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_octet (rsp_packed_octet),
      .rsp_final_octet  (rsp_final_octet)
   );

endmodule

`default_nettype wire

// File: src/gsm7_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gsm_7bit_text_encoder_unit_defines.svh"

module gsm7_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_packed_octet,
   input wire logic       rsp_final_octet
);

   // a stalled octet stays offered
   `GSM7_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")

   // a stalled octet keeps its value
   `GSM7_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_packed_octet) && $stable(rsp_final_octet), "rsp payload changed while stalled")

   // queue comes out of reset empty
   `GSM7_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid, "rsp_valid high after reset")

   // input register comes out of reset free
   `GSM7_ASSERT_NEXT_ALWAYS(a_req_reset, clock, reset, !req_stall, "req_stall high after reset")

endmodule

bind gsm_7bit_text_encoder_unit gsm7_checker u_gsm7_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_packed_octet (rsp_packed_octet),
   .rsp_final_octet  (rsp_final_octet)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned RANDOM_CHARS   = 2000;
   localparam int unsigned MAX_REPORTS    = 10;

   // gsm default alphabet as seen by the sender, index is the septet code
   localparam logic [7:0] GSM_CHARS [128] = '{
      8'd64,  8'd163, 8'd36,  8'd165, 8'd232, 8'd233, 8'd249, 8'd236, 8'd242, 8'd199,
      8'd10,  8'd216, 8'd248, 8'd13,  8'd197, 8'd229, 8'd16,  8'd95,  8'd18,  8'd19,
      8'd20,  8'd21,  8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd198, 8'd230,
      8'd223, 8'd201, 8'd32,  8'd33,  8'd34,  8'd35,  8'd164, 8'd37,  8'd38,  8'd39,
      8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
      8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
      8'd60,  8'd61,  8'd62,  8'd63,  8'd161, 8'd65,  8'd66,  8'd67,  8'd68,  8'd69,
      8'd70,  8'd71,  8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
      8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,  8'd89,
      8'd90,  8'd196, 8'd214, 8'd209, 8'd220, 8'd167, 8'd191, 8'd97,  8'd98,  8'd99,
      8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109,
      8'd110, 8'd111, 8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
      8'd120, 8'd121, 8'd122, 8'd228, 8'd246, 8'd241, 8'd252, 8'd224
   };

   typedef struct packed {
      logic [7:0] octet;
      logic       last_flag;
   } packed_octet_type;

   typedef logic [7:0] text_q_type [$];

   // septet packer model and the octets it still owes
   class octet_scoreboard;
      logic [2:0]       position;
      logic [6:0]       carry;
      packed_octet_type expected_q [$];
      int unsigned      mismatches;

      function new();
         position   = 3'd0;
         carry      = 7'd0;
         mismatches = 0;
      endfunction

      // first table match wins, unknown bytes give code 0
      function logic [6:0] septet_code(logic [7:0] text_byte);
         for (int k = 0; k < 128; k++) begin
            if (GSM_CHARS[k] == text_byte) return 7'(k);
         end
         return 7'd0;
      endfunction

      function void flag_error(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("%s", what);
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // accepted character: work out the octets it releases
      function void note_char(logic [7:0] text_byte, logic final_char);
         logic [6:0]       code;
         logic [15:0]      wide;
         packed_octet_type item;
         code = septet_code(text_byte);
         if (position == 3'd0) begin
            carry = code;
         end else begin
            wide = ({9'd0, code} << (8 - position)) | {9'd0, carry};
            item.octet     = wide[7:0];
            item.last_flag = final_char && (position == 3'd7);
            expected_q.push_back(item);
            carry = code >> position;
         end
         // end of message: flush the partial octet unless the group just closed
         if (final_char) begin
            if (position != 3'd7) begin
               item.octet     = {1'b0, carry};
               item.last_flag = 1'b1;
               expected_q.push_back(item);
            end
            position = 3'd0;
            carry    = 7'd0;
         end else begin
            position = position + 3'd1;
         end
      endfunction

      // accepted octet against the oldest one owed
      function void check_octet(logic [7:0] octet, logic final_flag);
         packed_octet_type want;
         if (expected_q.size() == 0) begin
            flag_error($sformatf("unexpected octet %02h final %0b", octet, final_flag));
            return;
         end
         want = expected_q.pop_front();
         if (want.octet !== octet || want.last_flag !== final_flag) begin
            flag_error($sformatf("octet mismatch: expected %02h final %0b, got %02h final %0b",
                                 want.octet, want.last_flag, octet, final_flag));
         end
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte  = 8'd0;
   logic       req_final_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_packed_octet;
   logic       rsp_final_octet;

   logic        no_gaps     = 1'b0;
   int unsigned quiet_edges = 0;
   octet_scoreboard sb;

   gsm_7bit_text_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_final_char   (req_final_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_octet (rsp_packed_octet),
      .rsp_final_octet  (rsp_final_octet)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(99) < 25);
   end

   // transfers on both channels, plus the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_char(req_text_byte, req_final_char);
         if (rsp_valid && !rsp_stall) sb.check_octet(rsp_packed_octet, rsp_final_octet);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_edges <= 0;
         end else if (quiet_edges >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end else begin
            quiet_edges <= quiet_edges + 1;
         end
      end
   end

   // one character transfer, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] text_byte, input logic final_char);
      while (!no_gaps && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= text_byte;
      req_final_char <= final_char;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_message(input text_q_type msg);
      for (int i = 0; i < msg.size(); i++) begin
         send_char(msg[i], i == msg.size() - 1);
      end
   endtask

   // sender holds off until every owed octet has come out
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // mostly alphabet characters, some arbitrary bytes and extremes
   function automatic logic [7:0] random_text_byte();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return GSM_CHARS[$urandom_range(127)];
      if (pick < 94) return 8'($urandom_range(255));
      return pick[0] ? 8'hff : 8'h00;
   endfunction

   initial begin
      text_q_type  msg;
      int unsigned sent;
      int unsigned len;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single unknown byte: flush only
      msg = '{8'hff};
      send_message(msg);
      // zero byte and '@' share code 0, ends on position one
      msg = '{8'h00, 8'h40};
      send_message(msg);
      // high bytes compared unsigned, ends on position six
      msg = '{8'he0, 8'h80, 8'h7f, 8'ha1, 8'h1b, 8'h0a, 8'he0};
      send_message(msg);
      // full group of eight: last regular octet closes the message
      msg = '{8'he0, 8'hfc, 8'hf1, 8'hf6, 8'he4, 8'h7a, 8'he0, 8'he0};
      send_message(msg);
      hold_until_drained();

      // random messages, one quiet stretch without any idling
      sent = 0;
      while (sent < RANDOM_CHARS) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
         no_gaps <= (sent >= 600 && sent < 1000);
         msg.delete();
         for (int i = 0; i < len; i++) msg.push_back(random_text_byte());
         send_message(msg);
         sent += len;
         if ($urandom_range(39) == 0) hold_until_drained();
      end
      hold_until_drained();
      repeat (10) @(posedge clock);

      if (sb.pending() != 0) sb.flag_error($sformatf("%0d octets never came", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
